[hw/rtl/chbt_pkg.sv]
// ----------------------------------------------------------------------------
// chbt_pkg
// Shared types, constants and helpers of the chunked body tracker.
// ----------------------------------------------------------------------------
package chbt_pkg;

	localparam int SIZE_BITS_DEF   = 32;
	localparam int LENGTH_BITS_DEF = 48;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_DIG0  = 8'h30;
	localparam logic [7:0] CHAR_DIG9  = 8'h39;
	localparam logic [7:0] CHAR_UPR_A = 8'h41;
	localparam logic [7:0] CHAR_UPR_F = 8'h46;
	localparam logic [7:0] CHAR_LWR_A = 8'h61;
	localparam logic [7:0] CHAR_LWR_F = 8'h66;
	localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

	typedef enum logic [7:0] {
		PH_HEX_FIRST = 8'b0000_0001,
		PH_HEX_MORE  = 8'b0000_0010,
		PH_LF        = 8'b0000_0100,
		PH_DATA      = 8'b0000_1000,
		PH_TAIL_CR   = 8'b0001_0000,
		PH_TAIL_LF   = 8'b0010_0000,
		PH_LAST      = 8'b0100_0000,
		PH_ERROR     = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_message;
		logic       segment_end;
	} item_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       hex_valid;
		logic [3:0] hex_digit;
		logic       is_cr;
		logic       is_lf;
		logic       restart;
		logic       seg_end;
	} token_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [31:0] chunk_left;
		logic [47:0] total_length;
		logic        last_chunk;
		logic        parse_error;
		logic        segment_end_out;
	} result_t;

	// {valid, value} of an ASCII hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CHAR_DIG0 && c <= CHAR_DIG9) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CHAR_UPR_A && c <= CHAR_UPR_F) ||
				(c >= CHAR_LWR_A && c <= CHAR_LWR_F)) begin
			r = {1'b1, c[3:0] + HEX_LETTER_OFS};
		end
		return r;
	endfunction

endpackage

[hw/rtl/http_chunked_body_tracker_top.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_tracker_top
// Byte-serial tracker for an HTTP/1.1 chunked message body.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: present item and raise push; a beat is
//   taken at a rising edge with push high and full low. Each beat carries one
//   body byte, start_of_message (restart parsing before this byte) and
//   segment_end (last byte of a buffer).
//   Result side is a queue read port: while empty is low the oldest result
//   stands on result; pop with empty low takes it. Every input beat yields
//   exactly one result beat, in order.
//   A taken byte passes the token queue, then the result queue, before its
//   result shows. Throughput: one byte per cycle while pop keeps the result
//   queue from filling. The back end's framing state machine updates its size,
//   count and saturating total together, so its loop closes every clock.
//   Stalls: holding pop low fills the result queue, then the back end halts
//   and the token queue fills; full rises with four bytes in flight.
//   Reset (arst_n low) empties both queues and returns the parser to the
//   start of a size line with zero count and zero total.
// ----------------------------------------------------------------------------
module http_chunked_body_tracker_top #(
	parameter int SIZE_BITS   = chbt_pkg::SIZE_BITS_DEF,
	parameter int LENGTH_BITS = chbt_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  chbt_pkg::item_t   item,
	output logic              full,
	input  logic              pop,
	output chbt_pkg::result_t result,
	output logic              empty
);
	import chbt_pkg::*;

	localparam int TOKW = $bits(token_t);
	localparam int RESW = $bits(result_t);

	token_t          tok_in;
	token_t          tok_out;
	logic [TOKW-1:0] tok_rdata;
	logic            tok_empty;
	logic            tok_pop;
	result_t         res;
	logic            res_push;
	logic            res_full;
	logic [RESW-1:0] res_rdata;

	// Front end: classify the byte as it arrives.
	chbt_front u_front (
		.item  (item),
		.token (tok_in)
	);

	// Token queue: decouple classification from the framing logic.
	chbt_fifo #(
		.WIDTH (TOKW),
		.DEPTH (QUEUE_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (TOKW'(tok_in)),
		.full   (full),
		.pop    (tok_pop),
		.rdata  (tok_rdata),
		.empty  (tok_empty)
	);

	assign tok_out = token_t'(tok_rdata);

	// Back end: advance the framing state, one token per beat.
	chbt_back #(
		.SIZE_BITS   (SIZE_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok_out),
		.tok_valid (!tok_empty),
		.tok_pop   (tok_pop),
		.res       (res),
		.res_ready (!res_full),
		.res_push  (res_push)
	);

	// Result queue: hold finished results while the receiver stalls.
	chbt_fifo #(
		.WIDTH (RESW),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (RESW'(res)),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign result = result_t'(res_rdata);

endmodule

[hw/rtl/chbt_fifo.sv]
// ----------------------------------------------------------------------------
// chbt_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module chbt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// hold payload, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hw/rtl/chbt_front.sv]
// ----------------------------------------------------------------------------
// chbt_front
// Classify each incoming byte: hex digit value, CR, LF, control flags.
// ----------------------------------------------------------------------------
module chbt_front (
	input  chbt_pkg::item_t  item,
	output chbt_pkg::token_t token
);
	import chbt_pkg::*;

	logic [4:0] hex;

	assign hex = hex_decode(item.data_byte);

	always_comb begin
		token.data_byte = item.data_byte;
		token.hex_valid = hex[4];
		token.hex_digit = hex[3:0];
		token.is_cr     = (item.data_byte == CHAR_CR);
		token.is_lf     = (item.data_byte == CHAR_LF);
		token.restart   = item.start_of_message;
		token.seg_end   = item.segment_end;
	end

endmodule

[hw/rtl/chbt_back.sv]
// ----------------------------------------------------------------------------
// chbt_back
// Chunk framing state machine: size parse, payload count, running total.
// ----------------------------------------------------------------------------
module chbt_back #(
	parameter int SIZE_BITS   = chbt_pkg::SIZE_BITS_DEF,
	parameter int LENGTH_BITS = chbt_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chbt_pkg::token_t  tok,
	input  logic              tok_valid,
	output logic              tok_pop,
	output chbt_pkg::result_t res,
	input  logic              res_ready,
	output logic              res_push
);
	import chbt_pkg::*;

	localparam int SUMW = ((SIZE_BITS > LENGTH_BITS) ? SIZE_BITS : LENGTH_BITS) + 1;
	localparam int CLW  = (SIZE_BITS > 32) ? SIZE_BITS : 32;
	localparam int TLW  = (LENGTH_BITS > 48) ? LENGTH_BITS : 48;

	phase_t                 ph_q, ph_e, ph_n;
	logic [SIZE_BITS-1:0]   acc_q, acc_e, acc_n;
	logic [SIZE_BITS-1:0]   rem_q, rem_e, rem_n, rem_dec;
	logic [LENGTH_BITS-1:0] tot_q, tot_e, tot_n;
	logic [SUMW-1:0]        sum;
	logic                   sat;
	logic                   valid;
	logic [CLW-1:0]         rem_wide;
	logic [TLW-1:0]         tot_wide;
	logic                   restart;

	assign tok_pop  = tok_valid && res_ready;
	assign res_push = tok_pop;

	// only a waiting token may restart the parser
	assign restart = tok_valid && tok.restart;

	// restart drops the stored state before this byte
	always_comb begin
		ph_e  = restart ? PH_HEX_FIRST : ph_q;
		acc_e = restart ? '0 : acc_q;
		rem_e = restart ? '0 : rem_q;
		tot_e = restart ? '0 : tot_q;
	end

	assign sum     = SUMW'(tot_e) + SUMW'(acc_e);
	assign sat     = |sum[SUMW-1:LENGTH_BITS];
	assign rem_dec = (rem_e == '0) ? '0 : rem_e - 1'b1;

	always_comb begin
		ph_n  = ph_e;
		acc_n = acc_e;
		rem_n = rem_e;
		tot_n = tot_e;
		valid = 1'b0;
		unique case (ph_e)
			PH_HEX_FIRST, PH_HEX_MORE: begin
				if (tok.hex_valid) begin
					if (acc_e[SIZE_BITS-1 -: 4] != '0) begin
						ph_n = PH_ERROR;
					end else begin
						acc_n = {acc_e[SIZE_BITS-5:0], tok.hex_digit};
						ph_n  = PH_HEX_MORE;
					end
				end else if (tok.is_cr && ph_e == PH_HEX_MORE) begin
					ph_n = PH_LF;
				end else begin
					ph_n = PH_ERROR;
				end
			end
			PH_LF: begin
				if (!tok.is_lf) begin
					ph_n = PH_ERROR;
				end else if (acc_e == '0) begin
					ph_n = PH_LAST;
				end else begin
					rem_n = acc_e;
					tot_n = sat ? '1 : sum[LENGTH_BITS-1:0];
					acc_n = '0;
					ph_n  = PH_DATA;
				end
			end
			PH_DATA: begin
				valid = 1'b1;
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					ph_n = PH_TAIL_CR;
				end
			end
			PH_TAIL_CR: begin
				ph_n = PH_TAIL_LF;
			end
			PH_TAIL_LF: begin
				ph_n  = PH_HEX_FIRST;
				acc_n = '0;
			end
			PH_LAST, PH_ERROR: begin
				ph_n = ph_e;
			end
			default: begin
				ph_n = PH_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HEX_FIRST;
			acc_q <= '0;
			rem_q <= '0;
			tot_q <= '0;
		end else if (tok_pop) begin
			ph_q  <= ph_n;
			acc_q <= acc_n;
			rem_q <= rem_n;
			tot_q <= tot_n;
		end
	end

	assign rem_wide = CLW'(rem_n);
	assign tot_wide = TLW'(tot_n);

	always_comb begin
		res.payload_valid   = valid;
		res.payload_byte    = tok.data_byte;
		res.chunk_left      = rem_wide[31:0];
		res.total_length    = tot_wide[47:0];
		res.last_chunk      = (ph_n == PH_LAST);
		res.parse_error     = (ph_n == PH_ERROR);
		res.segment_end_out = tok.seg_end;
	end

`ifndef SYNTHESIS
	a_data_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DATA) |-> (rem_q != '0))
		else $error("payload phase with zero bytes left");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_pop && !tok.restart && ph_q == PH_ERROR) |=> (ph_q == PH_ERROR))
		else $error("error cleared without restart");

	a_total_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_pop && !tok.restart) |=> (tot_q >= $past(tot_q)))
		else $error("running total decreased");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.payload_valid) |-> (!res.last_chunk && !res.parse_error))
		else $error("payload byte flagged last or error");
`endif

endmodule
